/* rtl/imbw_pkg.sv */
package imbw_pkg;

    localparam int unsigned DivWidth = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned BitCntWidth = 3;
    localparam logic [BitCntWidth-1:0] LastBit = 3'd7;
    localparam logic [DivWidth-1:0] DivReset = 16'd1;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_START     = 12'b0000_0000_0010,
        PH_ADDR_LOW  = 12'b0000_0000_0100,
        PH_ADDR_HIGH = 12'b0000_0000_1000,
        PH_AACK_LOW  = 12'b0000_0001_0000,
        PH_AACK_HIGH = 12'b0000_0010_0000,
        PH_DATA_LOW  = 12'b0000_0100_0000,
        PH_DATA_HIGH = 12'b0000_1000_0000,
        PH_DACK_LOW  = 12'b0001_0000_0000,
        PH_DACK_HIGH = 12'b0010_0000_0000,
        PH_STOP_LOW  = 12'b0100_0000_0000,
        PH_STOP_HIGH = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic done_res;
        logic address_acked;
        logic data_acked;
    } t_result;

endpackage

/* rtl/i2c_master_byte_write_top.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------
// in       | i_in_valid / o_in_stall   | start_request, target_byte, data_byte,
//          |                           | sda_sample (one timing tick)
// out      | o_out_valid / i_out_stall | scl_level, sda_level, busy_res,
//          |                           | done_res, address_acked, data_acked
// cfg      | i_cfg_we / i_cfg_data     | tick_divider
//
// One tick per cycle while o_in_stall is low; its result is in the output register in the cycle after it is taken.
// The bus sequencer updates in the same cycle the request is taken.
// Reset is synchronous, active low: lines released, divider 1, idle.
// o_in_stall is high only while a result is held and the output is stalled.
module i2c_master_byte_write_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [imbw_pkg::DivWidth-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_start_request,
    input  logic [imbw_pkg::ByteWidth-1:0] i_target_byte,
    input  logic [imbw_pkg::ByteWidth-1:0] i_data_byte,
    input  logic                           i_sda_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_scl_level,
    output logic                           o_sda_level,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_address_acked,
    output logic                           o_data_acked
);

    logic              req;
    imbw_pkg::t_result seq_result;
    imbw_pkg::t_result out_result;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign req        = i_in_valid & ~o_in_stall;

    imbw_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_req           (req),
        .i_start_request (i_start_request),
        .i_target_byte   (i_target_byte),
        .i_data_byte     (i_data_byte),
        .i_sda_sample    (i_sda_sample),
        .o_result        (seq_result)
    );

    imbw_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_result (seq_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_scl_level     = out_result.scl_level;
    assign o_sda_level     = out_result.sda_level;
    assign o_busy_res      = out_result.busy_res;
    assign o_done_res      = out_result.done_res;
    assign o_address_acked = out_result.address_acked;
    assign o_data_acked    = out_result.data_acked;

endmodule

/* rtl/imbw_seq.sv */
module imbw_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imbw_pkg::DivWidth-1:0]      i_cfg_data,
    input  logic                               i_req,
    input  logic                               i_start_request,
    input  logic [imbw_pkg::ByteWidth-1:0]     i_target_byte,
    input  logic [imbw_pkg::ByteWidth-1:0]     i_data_byte,
    input  logic                               i_sda_sample,
    output imbw_pkg::t_result                  o_result
);

    imbw_pkg::t_phase r_phase, n_phase;
    logic [imbw_pkg::BitCntWidth-1:0] r_bit_count, n_bit_count;
    logic [imbw_pkg::ByteWidth-1:0]   r_shift, n_shift;
    logic [imbw_pkg::ByteWidth-1:0]   r_held, n_held;
    logic [imbw_pkg::DivWidth-1:0]    r_tick, n_tick;
    logic [imbw_pkg::DivWidth-1:0]    r_div;
    logic r_scl, n_scl;
    logic r_sda, n_sda;
    logic r_aack, n_aack;
    logic r_dack, n_dack;
    logic n_done;

    logic [imbw_pkg::DivWidth-1:0] div_eff;
    logic [imbw_pkg::DivWidth:0]   tick_inc;
    logic                          phase_end;

    assign div_eff   = (r_div == '0) ? imbw_pkg::DivReset : r_div;
    assign tick_inc  = {1'b0, r_tick} + {{imbw_pkg::DivWidth{1'b0}}, 1'b1};
    assign phase_end = tick_inc >= {1'b0, div_eff};

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_held      = r_held;
        n_tick      = '0;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_aack      = r_aack;
        n_dack      = r_dack;
        n_done      = 1'b0;
        if (r_phase == imbw_pkg::PH_IDLE) begin
            n_scl = 1'b1;
            if (i_start_request) begin
                n_shift     = i_target_byte;
                n_held      = i_data_byte;
                n_bit_count = '0;
                n_aack      = 1'b0;
                n_dack      = 1'b0;
                n_phase     = imbw_pkg::PH_START;
                n_sda       = 1'b0;
            end else begin
                n_sda = 1'b1;
            end
        end else if (!phase_end) begin
            n_tick = tick_inc[imbw_pkg::DivWidth-1:0];
        end else begin
            unique case (r_phase)
                imbw_pkg::PH_START: begin
                    n_phase = imbw_pkg::PH_ADDR_LOW;
                    n_scl   = 1'b0;
                    n_sda   = r_shift[imbw_pkg::ByteWidth-1];
                end
                imbw_pkg::PH_ADDR_LOW, imbw_pkg::PH_DATA_LOW: begin
                    n_phase = (r_phase == imbw_pkg::PH_ADDR_LOW) ?
                              imbw_pkg::PH_ADDR_HIGH : imbw_pkg::PH_DATA_HIGH;
                    n_scl   = 1'b1;
                end
                imbw_pkg::PH_ADDR_HIGH, imbw_pkg::PH_DATA_HIGH: begin
                    n_scl = 1'b0;
                    if (r_bit_count == imbw_pkg::LastBit) begin
                        n_bit_count = '0;
                        n_phase = (r_phase == imbw_pkg::PH_ADDR_HIGH) ?
                                  imbw_pkg::PH_AACK_LOW : imbw_pkg::PH_DACK_LOW;
                        n_sda   = 1'b1;
                    end else begin
                        n_bit_count = r_bit_count + 1'b1;
                        n_shift = {r_shift[imbw_pkg::ByteWidth-2:0], 1'b0};
                        n_phase = (r_phase == imbw_pkg::PH_ADDR_HIGH) ?
                                  imbw_pkg::PH_ADDR_LOW : imbw_pkg::PH_DATA_LOW;
                        n_sda   = r_shift[imbw_pkg::ByteWidth-2];
                    end
                end
                imbw_pkg::PH_AACK_LOW, imbw_pkg::PH_DACK_LOW: begin
                    n_phase = (r_phase == imbw_pkg::PH_AACK_LOW) ?
                              imbw_pkg::PH_AACK_HIGH : imbw_pkg::PH_DACK_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                imbw_pkg::PH_AACK_HIGH: begin
                    n_aack = ~i_sda_sample;
                    n_scl  = 1'b0;
                    if (!i_sda_sample) begin
                        n_shift     = r_held;
                        n_bit_count = '0;
                        n_phase     = imbw_pkg::PH_DATA_LOW;
                        n_sda       = r_held[imbw_pkg::ByteWidth-1];
                    end else begin
                        n_phase = imbw_pkg::PH_STOP_LOW;
                        n_sda   = 1'b0;
                    end
                end
                imbw_pkg::PH_DACK_HIGH: begin
                    n_dack  = ~i_sda_sample;
                    n_phase = imbw_pkg::PH_STOP_LOW;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
                imbw_pkg::PH_STOP_LOW: begin
                    n_phase = imbw_pkg::PH_STOP_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                imbw_pkg::PH_STOP_HIGH: begin
                    n_phase = imbw_pkg::PH_IDLE;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_done  = 1'b1;
                end
                default: begin
                    n_phase = imbw_pkg::PH_IDLE;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= imbw_pkg::DivReset;
        end else if (i_cfg_we) begin
            r_div <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= imbw_pkg::PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_held      <= '0;
            r_tick      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_aack      <= 1'b0;
            r_dack      <= 1'b0;
        end else if (i_req) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_held      <= n_held;
            r_tick      <= n_tick;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_aack      <= n_aack;
            r_dack      <= n_dack;
        end
    end

    always_comb begin
        o_result.scl_level     = n_scl;
        o_result.sda_level     = n_sda;
        o_result.busy_res      = (n_phase != imbw_pkg::PH_IDLE);
        o_result.done_res      = n_done;
        o_result.address_acked = n_aack;
        o_result.data_acked    = n_dack;
    end

endmodule

/* rtl/imbw_out.sv */
module imbw_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req,
    input  imbw_pkg::t_result  i_result,
    input  logic               i_stall,
    output logic               o_valid,
    output imbw_pkg::t_result  o_result
);

    logic              r_valid;
    imbw_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/imbw_checker.sv */
module imbw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_scl_level,
    input logic o_sda_level,
    input logic o_busy_res,
    input logic o_done_res,
    input logic o_address_acked,
    input logic o_data_acked
);

    // done marks the end of a transaction, so the block is idle with it
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done while busy");

    // idle releases both lines
    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_level && o_sda_level)
        else $error("lines driven while idle");

    // data byte is only sent after an address ack
    a_data_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_acked |-> o_address_acked)
        else $error("data ack without address ack");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_scl_level)
            && $stable(o_sda_level) && $stable(o_done_res))
        else $error("stalled result changed");

    // input only backs up behind a held, stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

endmodule

bind i2c_master_byte_write_top imbw_checker u_imbw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_scl_level     (o_scl_level),
    .o_sda_level     (o_sda_level),
    .o_busy_res      (o_busy_res),
    .o_done_res      (o_done_res),
    .o_address_acked (o_address_acked),
    .o_data_acked    (o_data_acked)
);

/* sim/i2c_byte_write_checker.sv */
module i2c_byte_write_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [imbw_pkg::DivWidth-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_start_request,
    input  logic [imbw_pkg::ByteWidth-1:0] i_target_byte,
    input  logic [imbw_pkg::ByteWidth-1:0] i_data_byte,
    input  logic                           i_sda_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_scl_level,
    input  logic                           i_sda_level,
    input  logic                           i_busy_res,
    input  logic                           i_done_res,
    input  logic                           i_address_acked,
    input  logic                           i_data_acked,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_xfers,
    output int                             o_nacks
);

    logic [imbw_pkg::DivWidth-1:0]    divider;
    imbw_pkg::t_phase                 ph;
    logic [imbw_pkg::BitCntWidth-1:0] bit_cnt;
    logic [imbw_pkg::ByteWidth-1:0]   shreg;
    logic [imbw_pkg::ByteWidth-1:0]   data_hold;
    logic [imbw_pkg::DivWidth-1:0]    tick_cnt;
    logic                             scl_drv;
    logic                             sda_drv;
    logic                             addr_ack;
    logic                             data_ack;

    imbw_pkg::t_result line_q[$];
    int                fails;
    int                checked;
    int                xfers;
    int                nacks;

    function automatic void go(input imbw_pkg::t_phase nxt, input logic scl_n,
                               input logic sda_n);
        ph       = nxt;
        scl_drv  = scl_n;
        sda_drv  = sda_n;
        tick_cnt = '0;
    endfunction

    // end of the SCL-high half of an address or data bit
    function automatic void next_bit(input imbw_pkg::t_phase low_ph,
                                     input imbw_pkg::t_phase ack_ph);
        if (bit_cnt >= imbw_pkg::LastBit) begin
            bit_cnt = '0;
            go(ack_ph, 1'b0, 1'b1);
        end else begin
            bit_cnt = bit_cnt + 1'b1;
            shreg   = shreg << 1;
            go(low_ph, 1'b0, shreg[imbw_pkg::ByteWidth-1]);
        end
    endfunction

    task automatic step_bus_sequencer(input logic start,
                                      input logic [imbw_pkg::ByteWidth-1:0] tbyte,
                                      input logic [imbw_pkg::ByteWidth-1:0] dbyte,
                                      input logic sda_in,
                                      output imbw_pkg::t_result r);
        logic [imbw_pkg::DivWidth:0] div_eff;
        logic [imbw_pkg::DivWidth:0] tick_next;
        logic                        done;
        div_eff   = (divider == '0) ? {{imbw_pkg::DivWidth{1'b0}}, 1'b1}
                                    : {1'b0, divider};
        tick_next = {1'b0, tick_cnt} + {{imbw_pkg::DivWidth{1'b0}}, 1'b1};
        done      = 1'b0;
        if (ph == imbw_pkg::PH_IDLE) begin
            if (start) begin
                shreg     = tbyte;
                data_hold = dbyte;
                bit_cnt   = '0;
                addr_ack  = 1'b0;
                data_ack  = 1'b0;
                go(imbw_pkg::PH_START, 1'b1, 1'b0);
            end else begin
                go(imbw_pkg::PH_IDLE, 1'b1, 1'b1);
            end
        end else if (tick_next < div_eff) begin
            tick_cnt = tick_cnt + 1'b1;
        end else begin
            case (ph)
                imbw_pkg::PH_START:
                    go(imbw_pkg::PH_ADDR_LOW, 1'b0, shreg[imbw_pkg::ByteWidth-1]);
                imbw_pkg::PH_ADDR_LOW:  go(imbw_pkg::PH_ADDR_HIGH, 1'b1, sda_drv);
                imbw_pkg::PH_ADDR_HIGH: next_bit(imbw_pkg::PH_ADDR_LOW, imbw_pkg::PH_AACK_LOW);
                imbw_pkg::PH_AACK_LOW:  go(imbw_pkg::PH_AACK_HIGH, 1'b1, 1'b1);
                imbw_pkg::PH_AACK_HIGH: begin
                    addr_ack = ~sda_in;
                    if (addr_ack) begin
                        shreg   = data_hold;
                        bit_cnt = '0;
                        go(imbw_pkg::PH_DATA_LOW, 1'b0, shreg[imbw_pkg::ByteWidth-1]);
                    end else begin
                        nacks++;
                        go(imbw_pkg::PH_STOP_LOW, 1'b0, 1'b0);
                    end
                end
                imbw_pkg::PH_DATA_LOW:  go(imbw_pkg::PH_DATA_HIGH, 1'b1, sda_drv);
                imbw_pkg::PH_DATA_HIGH: next_bit(imbw_pkg::PH_DATA_LOW, imbw_pkg::PH_DACK_LOW);
                imbw_pkg::PH_DACK_LOW:  go(imbw_pkg::PH_DACK_HIGH, 1'b1, 1'b1);
                imbw_pkg::PH_DACK_HIGH: begin
                    data_ack = ~sda_in;
                    go(imbw_pkg::PH_STOP_LOW, 1'b0, 1'b0);
                end
                imbw_pkg::PH_STOP_LOW:  go(imbw_pkg::PH_STOP_HIGH, 1'b1, 1'b0);
                imbw_pkg::PH_STOP_HIGH: begin
                    go(imbw_pkg::PH_IDLE, 1'b1, 1'b1);
                    done = 1'b1;
                    xfers++;
                end
                default:      go(imbw_pkg::PH_IDLE, 1'b1, 1'b1);
            endcase
        end
        r.scl_level     = scl_drv;
        r.sda_level     = sda_drv;
        r.busy_res      = (ph != imbw_pkg::PH_IDLE);
        r.done_res      = done;
        r.address_acked = addr_ack;
        r.data_acked    = data_ack;
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        imbw_pkg::t_result want;
        imbw_pkg::t_result pred;
        if (!i_rst_n) begin
            divider   = imbw_pkg::DivReset;
            ph        = imbw_pkg::PH_IDLE;
            bit_cnt   = '0;
            shreg     = '0;
            data_hold = '0;
            tick_cnt  = '0;
            scl_drv   = 1'b1;
            sda_drv   = 1'b1;
            addr_ack  = 1'b0;
            data_ack  = 1'b0;
            line_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (line_q.size() == 0) begin
                    fails++;
                    $display("%0t: result mismatch, expected no result actual one", $time);
                end else begin
                    want = line_q.pop_front();
                    checked++;
                    check_field("scl_level", want.scl_level, i_scl_level);
                    check_field("sda_level", want.sda_level, i_sda_level);
                    check_field("busy_res", want.busy_res, i_busy_res);
                    check_field("done_res", want.done_res, i_done_res);
                    check_field("address_acked", want.address_acked, i_address_acked);
                    check_field("data_acked", want.data_acked, i_data_acked);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_bus_sequencer(i_start_request, i_target_byte, i_data_byte,
                                   i_sda_sample, pred);
                line_q.push_back(pred);
            end
            if (i_cfg_we) begin
                divider = i_cfg_data;
            end
        end
        o_fail_count <= fails;
        o_pending    <= line_q.size();
        o_checked    <= checked;
        o_xfers      <= xfers;
        o_nacks      <= nacks;
    end

endmodule

/* sim/i2c_master_byte_write_top_test.sv */
module i2c_master_byte_write_top_test;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 300;
    localparam int HoldAfter  = 600;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    logic       i_in_valid      = 1'b0;
    logic       i_start_request = 1'b0;
    logic [7:0] i_target_byte   = '0;
    logic [7:0] i_data_byte     = '0;
    logic       i_sda_sample    = 1'b1;
    logic       i_out_stall     = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_address_acked;
    logic       o_data_acked;

    int chk_fails;
    int chk_pending;
    int chk_checked;
    int chk_xfers;
    int chk_nacks;

    int n_sent     = 0;
    int burst_left = 0;

    // divider per phase, number of random ticks per phase
    int div_plan[6]   = '{1, 65535, 1, 2, 3, 4};
    int ticks_plan[6] = '{560, 30, 400, 350, 250, 200};

    i2c_master_byte_write_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_request (i_start_request),
        .i_target_byte   (i_target_byte),
        .i_data_byte     (i_data_byte),
        .i_sda_sample    (i_sda_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_scl_level     (o_scl_level),
        .o_sda_level     (o_sda_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_address_acked (o_address_acked),
        .o_data_acked    (o_data_acked)
    );

    i2c_byte_write_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_start_request (i_start_request),
        .i_target_byte   (i_target_byte),
        .i_data_byte     (i_data_byte),
        .i_sda_sample    (i_sda_sample),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_scl_level     (o_scl_level),
        .i_sda_level     (o_sda_level),
        .i_busy_res      (o_busy_res),
        .i_done_res      (o_done_res),
        .i_address_acked (o_address_acked),
        .i_data_acked    (o_data_acked),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked),
        .o_xfers         (chk_xfers),
        .o_nacks         (chk_nacks)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_tick(input logic start, input logic [7:0] tbyte,
                             input logic [7:0] dbyte, input logic sda);
        int gap;
        i_in_valid      <= 1'b1;
        i_start_request <= start;
        i_target_byte   <= tbyte;
        i_data_byte     <= dbyte;
        i_sda_sample    <= sda;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_random_tick(input logic force_start);
        logic start;
        start = force_start || ($urandom_range(0, 3) == 0);
        // acks mostly, so most transfers reach the data byte
        send_tick(start, 8'($urandom), 8'($urandom), $urandom_range(0, 9) >= 7);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    task automatic write_divider(input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // divider zero acts as one tick per half-phase
        write_divider(16'd0);
        send_tick(1'b0, 8'hFF, 8'hFF, 1'b1);
        send_tick(1'b1, 8'hFF, 8'h00, 1'b0);
        // start while busy: must be ignored
        send_tick(1'b1, 8'h00, 8'hFF, 1'b1);
        repeat (21) send_tick(1'b0, 8'h00, 8'h00, 1'b0);

        // divider changes land mid-transfer, incl. 65535 -> 1
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_divider(16'(div_plan[p]));
            for (int k = 0; k < ticks_plan[p]; k++) begin
                send_random_tick(div_plan[p] == 65535 && k == 0);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Run: %0d ticks sent, %0d results checked, dividers 0, 1..4 and 65535",
                 n_sent, chk_checked);
        $display("Bus: %0d transfers completed, %0d address nacks", chk_xfers, chk_nacks);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // output stall pattern, with one long hold-off to back up the input
    initial begin
        int  mode;
        int  span;
        bit  held;
        mode = 0;
        span = 0;
        held = 1'b0;
        forever begin
            if (!held && n_sent >= HoldAfter) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0: begin
                        i_out_stall <= 1'b0;
                    end
                    1: begin
                        i_out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no request or result moved for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
    end

endmodule
